### rtl/core/csrt_pkg.sv
package csrt_pkg;

	localparam int MOVEMENTS  = 8;
	localparam int TRAIN_BITS = 16;
	localparam int ISECT_BITS = 3;

	localparam int IDX_W  = $clog2(MOVEMENTS);
	localparam int MASK_W = 8;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [MOVEMENTS-1:0]  mov_vec_t;
	typedef logic [TRAIN_BITS-1:0] train_t;
	typedef logic [ISECT_BITS-1:0] isect_t;

	localparam logic [MASK_W-1:0] MOV_MASK = MASK_W'((16'd1 << MOVEMENTS) - 16'd1);
	localparam idx_t LAST_IDX = idx_t'(MOVEMENTS - 1);

	localparam logic [1:0] CMD_CHECK   = 2'd0;
	localparam logic [1:0] CMD_RESERVE = 2'd1;
	localparam logic [1:0] CMD_MARK    = 2'd2;
	localparam logic [1:0] CMD_CANCEL  = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY_TRAIN = 3'd1;
	localparam logic [2:0] ST_UNKNOWN     = 3'd2;
	localparam logic [2:0] ST_CONFLICT    = 3'd3;
	localparam logic [2:0] ST_OCCUPIED    = 3'd4;
	localparam logic [2:0] ST_PENDING     = 3'd5;
	localparam logic [2:0] ST_NONE_CLEAR  = 3'd6;

	localparam logic [2:0] REG_REGISTERED = 3'd0;
	localparam logic [2:0] REG_CONFLICT   = 3'd1;
	localparam logic [2:0] REG_CLR_LOW    = 3'd2;
	localparam logic [2:0] REG_CLR_HIGH   = 3'd3;
	localparam logic [2:0] REG_ISECT_MAP  = 3'd4;
	localparam logic [2:0] REG_DEFAULT    = 3'd5;

	typedef struct packed {
		logic [7:0]  registered;
		logic [63:0] conflict;
		logic [63:0] clr_low;
		logic [63:0] clr_high;
		logic [23:0] isect_map;
		logic [15:0] dflt_clr;
	} cfg_t;

	function automatic isect_t isect_of(input cfg_t cfg, input idx_t idx);
		return cfg.isect_map[3*idx +: ISECT_BITS];
	endfunction

	function automatic logic [15:0] clearance_of(input cfg_t cfg, input idx_t idx);
		logic [127:0] words;
		logic [15:0]  own;
		words = {cfg.clr_high, cfg.clr_low};
		own   = words[16*idx +: 16];
		return (own != 16'd0) ? own : cfg.dflt_clr;
	endfunction

endpackage

### rtl/core/csrt_req_if.sv
interface csrt_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic [7:0]                movement_mask;
	csrt_pkg::train_t          train;
	csrt_pkg::isect_t          intersection;
	logic [63:0]               now_ms;

	modport source (output valid, cmd, movement_mask, train, intersection, now_ms,
		input ready);
	modport sink (input valid, cmd, movement_mask, train, intersection, now_ms,
		output ready);
endinterface

### rtl/core/csrt_rsp_if.sv
interface csrt_rsp_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [2:0] status;
	logic [2:0] fail_movement;
	logic [2:0] fail_intersection;
	logic [7:0] active_mask;

	modport source (output valid, ok, status, fail_movement, fail_intersection, active_mask,
		input ready);
	modport sink (input valid, ok, status, fail_movement, fail_intersection, active_mask,
		output ready);
endinterface

### rtl/core/csrt_cfg_regs.sv
module csrt_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csrt_pkg::ADDR_W-1:0]  paddr,
	input  logic [csrt_pkg::DATA_W-1:0]  pwdata,
	output logic [csrt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output csrt_pkg::cfg_t               cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;
	csrt_pkg::cfg_t cfg_q;

	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				csrt_pkg::REG_REGISTERED: cfg_q.registered <= pwdata[7:0];
				csrt_pkg::REG_CONFLICT:   cfg_q.conflict   <= pwdata;
				csrt_pkg::REG_CLR_LOW:    cfg_q.clr_low    <= pwdata;
				csrt_pkg::REG_CLR_HIGH:   cfg_q.clr_high   <= pwdata;
				csrt_pkg::REG_ISECT_MAP:  cfg_q.isect_map  <= pwdata[23:0];
				csrt_pkg::REG_DEFAULT:    cfg_q.dflt_clr   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			csrt_pkg::REG_REGISTERED: prdata = {56'd0, cfg_q.registered};
			csrt_pkg::REG_CONFLICT:   prdata = cfg_q.conflict;
			csrt_pkg::REG_CLR_LOW:    prdata = cfg_q.clr_low;
			csrt_pkg::REG_CLR_HIGH:   prdata = cfg_q.clr_high;
			csrt_pkg::REG_ISECT_MAP:  prdata = {40'd0, cfg_q.isect_map};
			csrt_pkg::REG_DEFAULT:    prdata = {48'd0, cfg_q.dflt_clr};
			default:                  prdata = '0;
		endcase
	end

endmodule

### rtl/core/csrt_pair_unit.sv
module csrt_pair_unit (
	input  csrt_pkg::cfg_t     cfg,
	input  csrt_pkg::idx_t     row_idx,
	input  csrt_pkg::idx_t     col_idx,
	input  logic [63:0]        now_ms,
	input  logic [63:0]        stamp,
	output csrt_pkg::mov_vec_t conflict_row,
	output logic               clear_short
);

	csrt_pkg::isect_t row_isect;
	logic [15:0]      clr_row;
	logic [15:0]      clr_col;
	logic [15:0]      need;
	logic [64:0]      elapsed;

	always_comb begin
		row_isect = csrt_pkg::isect_of(cfg, row_idx);
		for (int j = 0; j < csrt_pkg::MOVEMENTS; j++) begin
			conflict_row[j] =
				(csrt_pkg::isect_of(cfg, csrt_pkg::idx_t'(j)) == row_isect) &&
				((row_idx == csrt_pkg::idx_t'(j)) ||
				 cfg.conflict[{3'(row_idx), 3'(j)}] ||
				 cfg.conflict[{3'(j), 3'(row_idx)}]);
		end
	end

	// larger of the two clearances against time since the stamp
	always_comb begin
		clr_row     = csrt_pkg::clearance_of(cfg, row_idx);
		clr_col     = csrt_pkg::clearance_of(cfg, col_idx);
		need        = (clr_row > clr_col) ? clr_row : clr_col;
		elapsed     = {1'b0, now_ms} - {1'b0, stamp};
		clear_short = conflict_row[col_idx] &&
			(elapsed[64] || (elapsed[63:0] < {48'd0, need}));
	end

endmodule

### rtl/core/conflict_set_reservation_table.sv
// Reservation table for up to eight movements. Each request is a command
// transfer on the request channel and gives exactly one transfer on the
// response channel; the block takes one request at a time and is not ready
// while it works. Mark cleared and cancel pass from acceptance through the
// release state to the done state. A reserve for an empty train, or a check
// or reserve naming an unknown movement, goes straight to the done state;
// otherwise the request is scanned pairwise, then each movement index is
// walked and each requested one is checked against every stored movement.
// The walk is serialised on the single conflict and 64-bit clearance
// comparator, shared by every pair in the walk. A finished result
// sits in an output register, so a new request is accepted while it waits.
// Configuration registers sit at byte address 8*index on the APB port.
module conflict_set_reservation_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csrt_pkg::ADDR_W-1:0]  paddr,
	input  logic [csrt_pkg::DATA_W-1:0]  pwdata,
	output logic [csrt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	csrt_req_if.sink                     request,
	csrt_rsp_if.source                   response
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAIR,
		S_ROW,
		S_CLEAR,
		S_RELEASE,
		S_DONE
	} state_t;

	state_t               state_q;
	csrt_pkg::cfg_t       cfg;
	logic [1:0]           cmd_q;
	csrt_pkg::mov_vec_t   req_q;
	csrt_pkg::train_t     train_q;
	csrt_pkg::isect_t     isect_q;
	logic [63:0]          now_q;
	csrt_pkg::idx_t       i_q;
	csrt_pkg::idx_t       k_q;
	logic [2:0]           status_q;
	logic [2:0]           fmov_q;
	logic [2:0]           fisect_q;
	csrt_pkg::mov_vec_t   active_q;
	csrt_pkg::mov_vec_t   clear_valid_q;
	csrt_pkg::train_t     holder_q [csrt_pkg::MOVEMENTS];
	logic [63:0]          stamp_q  [csrt_pkg::MOVEMENTS];
	logic                 out_valid_q;
	logic                 out_ok_q;
	logic [2:0]           out_status_q;
	logic [2:0]           out_fmov_q;
	logic [2:0]           out_fisect_q;
	logic [7:0]           out_active_q;

	csrt_pkg::mov_vec_t   reg_vec;
	csrt_pkg::mov_vec_t   higher;
	csrt_pkg::mov_vec_t   conflict_row;
	csrt_pkg::mov_vec_t   match_train;
	csrt_pkg::mov_vec_t   match_mark;
	logic [7:0]           unknown;
	logic [2:0]           unknown_idx;
	logic                 clear_short;
	logic                 accept;
	logic                 commit;
	csrt_pkg::isect_t     row_isect;

	csrt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csrt_pair_unit u_pair (
		.cfg          (cfg),
		.row_idx      (i_q),
		.col_idx      (k_q),
		.now_ms       (now_q),
		.stamp        (stamp_q[k_q]),
		.conflict_row (conflict_row),
		.clear_short  (clear_short)
	);

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;

	assign response.valid             = out_valid_q;
	assign response.ok                = out_ok_q;
	assign response.status            = out_status_q;
	assign response.fail_movement     = out_fmov_q;
	assign response.fail_intersection = out_fisect_q;
	assign response.active_mask       = out_active_q;

	always_comb begin
		reg_vec   = cfg.registered[csrt_pkg::MOVEMENTS-1:0];
		unknown   = request.movement_mask & ~(cfg.registered & csrt_pkg::MOV_MASK);
		higher    = (csrt_pkg::mov_vec_t'('1) << i_q) << 1;
		row_isect = csrt_pkg::isect_of(cfg, i_q);
		unknown_idx = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (unknown[j]) begin
				unknown_idx = 3'(j);
			end
		end
		for (int j = 0; j < csrt_pkg::MOVEMENTS; j++) begin
			match_train[j] = active_q[j] && (holder_q[j] == train_q);
			match_mark[j]  = match_train[j] &&
				(csrt_pkg::isect_of(cfg, csrt_pkg::idx_t'(j)) == isect_q);
		end
	end

	// request passes all checks once the last index has been walked
	always_comb begin
		commit = 1'b0;
		case (state_q)
			S_ROW:   commit = !req_q[i_q] && (i_q == csrt_pkg::LAST_IDX);
			S_CLEAR: commit = !(clear_valid_q[k_q] && reg_vec[k_q] && clear_short) &&
				(k_q == csrt_pkg::LAST_IDX) && (i_q == csrt_pkg::LAST_IDX);
			default: commit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= '0;
			clear_valid_q <= '0;
			out_valid_q   <= 1'b0;
			cmd_q         <= csrt_pkg::CMD_CHECK;
			req_q         <= '0;
			train_q       <= '0;
			isect_q       <= '0;
			now_q         <= '0;
			i_q           <= '0;
			k_q           <= '0;
			status_q      <= csrt_pkg::ST_OK;
			fmov_q        <= '0;
			fisect_q      <= '0;
			out_ok_q      <= 1'b0;
			out_status_q  <= csrt_pkg::ST_OK;
			out_fmov_q    <= '0;
			out_fisect_q  <= '0;
			out_active_q  <= '0;
		end else begin
			if (response.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				status_q <= csrt_pkg::ST_OK;
				state_q  <= S_DONE;
				if (cmd_q == csrt_pkg::CMD_RESERVE) begin
					active_q <= active_q | req_q;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= request.cmd;
						req_q    <= request.movement_mask[csrt_pkg::MOVEMENTS-1:0];
						train_q  <= request.train;
						isect_q  <= request.intersection;
						now_q    <= request.now_ms;
						i_q      <= '0;
						k_q      <= '0;
						status_q <= csrt_pkg::ST_OK;
						fmov_q   <= '0;
						fisect_q <= '0;
						if (request.cmd == csrt_pkg::CMD_MARK ||
							request.cmd == csrt_pkg::CMD_CANCEL) begin
							state_q <= S_RELEASE;
						end else if (request.cmd == csrt_pkg::CMD_RESERVE &&
							request.train == '0) begin
							status_q <= csrt_pkg::ST_EMPTY_TRAIN;
							state_q  <= S_DONE;
						end else if (unknown != 8'd0) begin
							status_q <= csrt_pkg::ST_UNKNOWN;
							fmov_q   <= unknown_idx;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_PAIR;
						end
					end
				end
				S_PAIR: begin
					if (req_q[i_q] && ((conflict_row & req_q & higher) != '0)) begin
						status_q <= csrt_pkg::ST_CONFLICT;
						fmov_q   <= 3'(i_q);
						state_q  <= S_DONE;
					end else if (i_q == csrt_pkg::LAST_IDX) begin
						i_q     <= '0;
						state_q <= S_ROW;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_ROW: begin
					if (!req_q[i_q]) begin
						if (i_q != csrt_pkg::LAST_IDX) begin
							i_q <= i_q + 1'b1;
						end
					end else if ((conflict_row & active_q & reg_vec) != '0) begin
						status_q <= csrt_pkg::ST_OCCUPIED;
						fisect_q <= 3'(row_isect);
						state_q  <= S_DONE;
					end else begin
						k_q     <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					if (clear_valid_q[k_q] && reg_vec[k_q] && clear_short) begin
						status_q <= csrt_pkg::ST_PENDING;
						fisect_q <= 3'(row_isect);
						state_q  <= S_DONE;
					end else if (k_q == csrt_pkg::LAST_IDX) begin
						if (i_q != csrt_pkg::LAST_IDX) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_ROW;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_RELEASE: begin
					state_q <= S_DONE;
					if (cmd_q == csrt_pkg::CMD_MARK) begin
						if (match_mark != '0) begin
							active_q      <= active_q & ~match_mark;
							clear_valid_q <= clear_valid_q | match_mark;
							status_q      <= csrt_pkg::ST_OK;
						end else begin
							status_q <= csrt_pkg::ST_NONE_CLEAR;
						end
					end else begin
						active_q <= active_q & ~match_train;
						status_q <= csrt_pkg::ST_OK;
					end
				end
				S_DONE: begin
					if (!out_valid_q || response.ready) begin
						out_valid_q  <= 1'b1;
						out_ok_q     <= (status_q == csrt_pkg::ST_OK);
						out_status_q <= status_q;
						out_fmov_q   <= fmov_q;
						out_fisect_q <= fisect_q;
						out_active_q <= 8'(active_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < csrt_pkg::MOVEMENTS; j++) begin
			if (commit && cmd_q == csrt_pkg::CMD_RESERVE && req_q[j]) begin
				holder_q[j] <= train_q;
			end
			if (state_q == S_RELEASE && cmd_q == csrt_pkg::CMD_MARK && match_mark[j]) begin
				stamp_q[j] <= now_q;
			end
		end
	end

endmodule
